[hw/rtl/bsd_pkg.sv]
// ----------------------------------------------------------------------------
// bsd_pkg
// Shared types and constants of the binary STL record deframer.
// ----------------------------------------------------------------------------
package bsd_pkg;

    localparam int SIZE_W   = 40;
    localparam int POS_W    = 7;
    localparam int SUM_W    = 38;
    localparam int OFF_W    = 6;
    localparam int WITHIN_W = 4;

    localparam int HEADER_BYTES = 80;
    localparam int COUNT_BYTES  = 4;
    localparam int RECORD_BYTES = 50;
    localparam int VECTOR_BYTES = 12;
    localparam int ATTR_OFFSET  = 48;

    localparam logic [POS_W-1:0] CNT_POS      = POS_W'(HEADER_BYTES);
    localparam logic [POS_W-1:0] LAST_HDR_POS = POS_W'(HEADER_BYTES + COUNT_BYTES - 1);
    localparam logic [POS_W-1:0] REC_POS      = POS_W'(HEADER_BYTES + COUNT_BYTES);

    localparam logic [SIZE_W-1:0] MIN_SIZE   = SIZE_W'(HEADER_BYTES + COUNT_BYTES);
    localparam logic [SIZE_W-1:0] TRUNC_BASE = SIZE_W'(HEADER_BYTES + COUNT_BYTES
                                                       - RECORD_BYTES);

    localparam logic [OFF_W-1:0]    ATTR_LO_OFF = OFF_W'(ATTR_OFFSET);
    localparam logic [WITHIN_W-1:0] LAST_WITHIN = WITHIN_W'(VECTOR_BYTES - 1);

    // queue between front and back
    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    // item kinds in the queue
    localparam logic [1:0] ITEM_HDR = 2'd0;
    localparam logic [1:0] ITEM_CNT = 2'd1;
    localparam logic [1:0] ITEM_VEC = 2'd2;

    // result status codes
    localparam logic [1:0] ST_VECTOR     = 2'd0;
    localparam logic [1:0] ST_EMPTY      = 2'd1;
    localparam logic [1:0] ST_NOT_BINARY = 2'd2;
    localparam logic [1:0] ST_TRUNCATED  = 2'd3;

    localparam logic [1:0] KIND_LAST_VERTEX = 2'd3;

    typedef struct packed {
        logic [1:0]       kind;
        logic             first;
        logic [1:0]       vec_kind;
        logic [31:0]      x;
        logic [31:0]      y;
        logic [31:0]      z;
        logic [15:0]      attr;
        logic [31:0]      tri_idx;
        logic             last;
        logic [SUM_W-1:0] sum50;
    } t_item;

    typedef struct packed {
        logic [1:0]  status;
        logic [1:0]  vector_kind;
        logic [31:0] x_bits;
        logic [31:0] y_bits;
        logic [31:0] z_bits;
        logic [15:0] attribute;
        logic [31:0] triangle_index;
        logic        last_of_file;
    } t_result;

endpackage

[hw/rtl/bsd_front.sv]
// ----------------------------------------------------------------------------
// bsd_front
// Tracks the byte position, gathers the triangle count and assembles the
// vectors of each record; hands one item per relevant byte to the queue.
// ----------------------------------------------------------------------------
module bsd_front import bsd_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  logic [7:0] i_data_byte,
    input  logic       i_first_byte,
    output logic       o_push,
    output t_item      o_item
);

    logic [POS_W-1:0]    r_pos, n_pos;
    logic [SUM_W-1:0]    r_sum50, n_sum50;
    logic [23:0]         r_cnt, n_cnt;
    logic [31:0]         r_cnt_m1, n_cnt_m1;
    logic [OFF_W-1:0]    r_off, n_off;
    logic [WITHIN_W-1:0] r_within, n_within;
    logic [1:0]          r_vec, n_vec;
    logic [31:0]         r_tri, n_tri;
    logic [7:0]          r_attr_lo, n_attr_lo;
    logic [7:0]          r_vbuf [VECTOR_BYTES];
    logic [7:0]          n_vbuf [VECTOR_BYTES];

    logic [POS_W-1:0] c_pos;
    logic [SUM_W-1:0] c_sum;
    logic [23:0]      c_cnt;
    logic [13:0]      prod;
    logic [SUM_W-1:0] sh_prod;

    // a first byte restarts the file before the byte is taken
    assign c_pos = i_first_byte ? '0 : r_pos;
    assign c_sum = i_first_byte ? '0 : r_sum50;
    assign c_cnt = i_first_byte ? '0 : r_cnt;

    // byte times fifty, placed at its count byte lane
    assign prod    = (14'(i_data_byte) << 5) + (14'(i_data_byte) << 4)
                   + (14'(i_data_byte) << 1);
    assign sh_prod = SUM_W'(prod) << {c_pos[1:0], 3'b000};

    always_comb begin
        n_pos     = r_pos;
        n_sum50   = r_sum50;
        n_cnt     = r_cnt;
        n_cnt_m1  = r_cnt_m1;
        n_off     = r_off;
        n_within  = r_within;
        n_vec     = r_vec;
        n_tri     = r_tri;
        n_attr_lo = r_attr_lo;
        n_vbuf    = r_vbuf;
        o_push    = 1'b0;
        o_item    = '0;
        o_item.first   = i_first_byte;
        o_item.tri_idx = r_tri;

        if (c_pos != REC_POS) begin
            n_pos   = c_pos + 1'b1;
            n_sum50 = c_sum;
            n_cnt   = c_cnt;
            o_push  = i_accept;
            o_item.kind = ITEM_HDR;
            if (c_pos >= CNT_POS) begin
                n_sum50 = c_sum + sh_prod;
                case (c_pos[1:0])
                    2'd0:    n_cnt[7:0]   = i_data_byte;
                    2'd1:    n_cnt[15:8]  = i_data_byte;
                    2'd2:    n_cnt[23:16] = i_data_byte;
                    default: n_cnt        = c_cnt;
                endcase
                if (c_pos == LAST_HDR_POS) begin
                    o_item.kind  = ITEM_CNT;
                    o_item.sum50 = n_sum50;
                    n_cnt_m1     = {i_data_byte, c_cnt} - 32'd1;
                    n_off        = '0;
                    n_within     = '0;
                    n_vec        = '0;
                    n_tri        = '0;
                end
            end
        end else if (r_off < ATTR_LO_OFF) begin
            n_vbuf[r_within] = i_data_byte;
            n_off            = r_off + 1'b1;
            if (r_within == LAST_WITHIN) begin
                n_within = '0;
                n_vec    = r_vec + 1'b1;
                // the third vertex waits for the attribute word
                if (r_vec != KIND_LAST_VERTEX) begin
                    o_push          = i_accept;
                    o_item.kind     = ITEM_VEC;
                    o_item.vec_kind = r_vec;
                    o_item.x = {n_vbuf[3], n_vbuf[2], n_vbuf[1], n_vbuf[0]};
                    o_item.y = {n_vbuf[7], n_vbuf[6], n_vbuf[5], n_vbuf[4]};
                    o_item.z = {n_vbuf[11], n_vbuf[10], n_vbuf[9], n_vbuf[8]};
                end
            end else begin
                n_within = r_within + 1'b1;
            end
        end else if (r_off == ATTR_LO_OFF) begin
            n_attr_lo = i_data_byte;
            n_off     = r_off + 1'b1;
        end else begin
            o_push          = i_accept;
            o_item.kind     = ITEM_VEC;
            o_item.vec_kind = KIND_LAST_VERTEX;
            o_item.x        = {r_vbuf[3], r_vbuf[2], r_vbuf[1], r_vbuf[0]};
            o_item.y        = {r_vbuf[7], r_vbuf[6], r_vbuf[5], r_vbuf[4]};
            o_item.z        = {r_vbuf[11], r_vbuf[10], r_vbuf[9], r_vbuf[8]};
            o_item.attr     = {i_data_byte, r_attr_lo};
            o_item.last     = (r_tri == r_cnt_m1);
            n_off    = '0;
            n_within = '0;
            n_vec    = '0;
            n_tri    = r_tri + 32'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos    <= '0;
            r_sum50  <= '0;
            r_cnt    <= '0;
            r_cnt_m1 <= '0;
            r_off    <= '0;
            r_within <= '0;
            r_vec    <= '0;
            r_tri    <= '0;
        end else if (i_accept) begin
            r_pos    <= n_pos;
            r_sum50  <= n_sum50;
            r_cnt    <= n_cnt;
            r_cnt_m1 <= n_cnt_m1;
            r_off    <= n_off;
            r_within <= n_within;
            r_vec    <= n_vec;
            r_tri    <= n_tri;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_attr_lo <= n_attr_lo;
            r_vbuf    <= n_vbuf;
        end
    end

endmodule

[hw/rtl/bsd_queue.sv]
// ----------------------------------------------------------------------------
// bsd_queue
// Short first-in first-out queue of items between front and back.
// ----------------------------------------------------------------------------
module bsd_queue import bsd_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_item,
    output logic  o_full,
    input  logic  i_pop,
    output logic  o_valid,
    output t_item o_item
);

    t_item               r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0]  r_wr_ptr, r_rd_ptr;
    logic [Q_CNT_W-1:0]  r_count, n_count;
    logic                do_push, do_pop;

    assign o_full  = (r_count == Q_CNT_W'(Q_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_count = r_count;
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

endmodule

[hw/rtl/bsd_back.sv]
// ----------------------------------------------------------------------------
// bsd_back
// Classifies the file against its size, drops items after the final
// result and holds the result register seen on the output side.
// ----------------------------------------------------------------------------
module bsd_back import bsd_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [SIZE_W-1:0] i_file_size,
    input  logic              i_q_valid,
    input  t_item             i_item,
    output logic              o_q_pop,
    input  logic              i_pop,
    output logic              o_valid,
    output t_result           o_result
);

    logic [SIZE_W-1:0] r_size_m84, r_size_m34;
    logic              r_short;
    logic              r_done, n_done;
    logic              r_out_valid;
    t_result           r_out;

    logic              take, done_eff, emit;
    logic [SIZE_W-1:0] sum_ext;
    logic              fit_eq, fit_gt, fit_le;
    t_result           res;

    // size terms kept in registers; the user must change the size only while idle, the block does not enforce it
    always_ff @(posedge i_clk) begin
        r_size_m84 <= i_file_size - MIN_SIZE;
        r_size_m34 <= i_file_size - TRUNC_BASE;
        r_short    <= (i_file_size < MIN_SIZE);
    end

    assign take     = i_q_valid && (!r_out_valid || i_pop);
    assign o_q_pop  = take;
    assign done_eff = i_item.first ? 1'b0 : r_done;
    assign sum_ext  = SIZE_W'(i_item.sum50);
    assign fit_eq   = (sum_ext == r_size_m84);
    assign fit_gt   = (sum_ext > r_size_m84);
    assign fit_le   = (sum_ext <= r_size_m34);

    always_comb begin
        emit   = 1'b0;
        n_done = done_eff;
        res    = '0;
        res.last_of_file = 1'b1;
        if (!done_eff) begin
            case (i_item.kind)
                ITEM_HDR: begin
                    if (r_short) begin
                        emit       = 1'b1;
                        n_done     = 1'b1;
                        res.status = ST_NOT_BINARY;
                    end
                end
                ITEM_CNT: begin
                    n_done = 1'b1;
                    emit   = 1'b1;
                    if (r_short) begin
                        res.status = ST_NOT_BINARY;
                    end else if (fit_eq) begin
                        if (sum_ext == '0) begin
                            res.status = ST_EMPTY;
                        end else begin
                            // exact fit with records to follow
                            emit   = 1'b0;
                            n_done = 1'b0;
                        end
                    end else if (fit_gt && fit_le) begin
                        res.status = ST_TRUNCATED;
                    end else begin
                        res.status = ST_NOT_BINARY;
                    end
                end
                ITEM_VEC: begin
                    emit               = 1'b1;
                    n_done             = i_item.last;
                    res.status         = ST_VECTOR;
                    res.vector_kind    = i_item.vec_kind;
                    res.x_bits         = i_item.x;
                    res.y_bits         = i_item.y;
                    res.z_bits         = i_item.z;
                    res.attribute      = i_item.attr;
                    res.triangle_index = i_item.tri_idx;
                    res.last_of_file   = i_item.last;
                end
                default: begin
                    emit = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (take) begin
                r_done <= n_done;
            end
            if (take && emit) begin
                r_out_valid <= 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take && emit) begin
            r_out <= res;
        end
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_out;

endmodule

[hw/rtl/binary_stl_record_deframer_top.sv]
// ----------------------------------------------------------------------------
// binary_stl_record_deframer_top
// Path: each item is registered in the queue, then its result in the back's result register.
// Throughput: one byte per cycle while the queue is not full, set by the front's per-byte counters.
// Reset: synchronous, active low; file size clears to zero and the first byte
// after reset starts a file.
// ----------------------------------------------------------------------------
module binary_stl_record_deframer_top import bsd_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [SIZE_W-1:0] i_cfg_wdata,
    input  logic              push,
    output logic              full,
    input  logic [7:0]        i_data_byte,
    input  logic              i_first_byte,
    output logic              empty,
    input  logic              pop,
    output logic [1:0]        o_status,
    output logic [1:0]        o_vector_kind,
    output logic [31:0]       o_x_bits,
    output logic [31:0]       o_y_bits,
    output logic [31:0]       o_z_bits,
    output logic [15:0]       o_attribute,
    output logic [31:0]       o_triangle_index,
    output logic              o_last_of_file
);

    logic [SIZE_W-1:0] r_file_size;
    logic              accept;
    logic              front_push;
    t_item             front_item;
    logic              q_full, q_valid, q_pop;
    t_item             q_item;
    logic              out_valid;
    t_result           out_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_file_size <= '0;
        end else if (i_cfg_we) begin
            r_file_size <= i_cfg_wdata;
        end
    end

    assign full   = q_full;
    assign accept = push && !q_full;

    bsd_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (accept),
        .i_data_byte  (i_data_byte),
        .i_first_byte (i_first_byte),
        .o_push       (front_push),
        .o_item       (front_item)
    );

    bsd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_push),
        .i_item  (front_item),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_item  (q_item)
    );

    bsd_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_file_size (r_file_size),
        .i_q_valid   (q_valid),
        .i_item      (q_item),
        .o_q_pop     (q_pop),
        .i_pop       (pop),
        .o_valid     (out_valid),
        .o_result    (out_res)
    );

    assign empty            = !out_valid;
    assign o_status         = out_res.status;
    assign o_vector_kind    = out_res.vector_kind;
    assign o_x_bits         = out_res.x_bits;
    assign o_y_bits         = out_res.y_bits;
    assign o_z_bits         = out_res.z_bits;
    assign o_attribute      = out_res.attribute;
    assign o_triangle_index = out_res.triangle_index;
    assign o_last_of_file   = out_res.last_of_file;

endmodule
